@@ design/cgpa_pkg.sv @@
package cgpa_pkg;

  // input word kinds
  typedef enum logic [2:0] {
    K_JOIN      = 3'd0,
    K_LEAVE     = 3'd1,
    K_HEARTBEAT = 3'd2,
    K_TOPIC     = 3'd3,
    K_QUERY     = 3'd4
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_HB_MUL,
    S_HB_CMP,
    S_Q_RD,
    S_Q_EMIT,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RG_LEN,
    S_RG_GIVE,
    S_RR,
    S_SYNC_END,
    S_EMIT
  } state_e;

  // one member record in the record memory
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] seen;
    logic [30:0] tmo;
  } rec_t;

  localparam int PID_W = 11;
  // floor(x/1000) = (x * RECIP) >> 41 for any 31-bit x
  localparam logic [31:0] DIV1000_RECIP = 32'd2199023256;
  localparam int DIV1000_SHIFT = 41;
  localparam int PC_MAX = 255;

endpackage

@@ design/cgpa_ram.sv @@
module cgpa_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                         wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [W-1:0]                         rdata_o
);

  logic [W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ design/cgpa_div.sv @@
module cgpa_div #(
  parameter int NW = 14,
  parameter int DW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [NW-1:0]   quot_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     trial;
  logic            fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, quot_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      quot_q <= {quot_q[NW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ design/consumer_group_partition_assigner.sv @@
// Consumer group partition assigner. One word is taken at a time: in_ready_o
// is high only while the sequencer is idle. Join, leave, heartbeat and query
// search the member table in record memory, reading each member scanned and
// then comparing its key. A topic word that is not last only records its
// count. The last topic runs the assignment: range mode sums the topic
// counts (one cycle a topic), divides in a shift-subtract unit (one cycle a
// bit) and, within each member's block, writes one partition a cycle into
// partition memory, capped per member; round robin walks every partition of
// every topic in turn, one member after another, and leaves a partition
// unassigned when its member is full. A query then delivers one result word
// per assigned partition; each word waits for the registered read of
// partition memory. Leave closes the gap by shifting a small slot map, so it
// never copies memory. No clearing pass is needed after reset.
module consumer_group_partition_assigner
  import cgpa_pkg::*;
#(
  parameter int MEMBERS          = 8,
  parameter int SLOTS_PER_MEMBER = 16,
  parameter int TOPICS           = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] member_key_i,
  input  logic [30:0] timeout_ms_i,
  input  logic [31:0] now_seconds_i,
  input  logic [7:0]  partition_count_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [10:0] partition_id_o,
  output logic        has_partition_o,
  output logic [4:0]  assigned_count_o,
  output logic        last_o,
  output logic [3:0]  member_total_o,
  output logic [31:0] generation_o,
  output logic        rebalancing_o
);

  localparam int IW     = MEMBERS > 1 ? $clog2(MEMBERS) : 1;
  localparam int CW     = $clog2(MEMBERS + 1);
  localparam int PCW    = $clog2(SLOTS_PER_MEMBER + 1);
  localparam int TLW    = $clog2(TOPICS + 1);
  localparam int TIW    = TOPICS > 1 ? $clog2(TOPICS) : 1;
  localparam int TW     = $clog2(TOPICS * PC_MAX + 1);
  localparam int PDEPTH = MEMBERS * SLOTS_PER_MEMBER;
  localparam int PAW    = PDEPTH > 1 ? $clog2(PDEPTH) : 1;
  localparam int RW     = $bits(rec_t);

  state_e state_q, state_d;

  // control state
  logic             strat_q;
  logic [CW-1:0]    n_q;
  logic [31:0]      gen_q;
  logic             reb_q;
  logic [TLW-1:0]   tl_q;
  logic             active_q [MEMBERS];
  logic [PCW-1:0]   cnt_q [MEMBERS];
  logic [IW-1:0]    map_q [MEMBERS];
  logic             out_valid_q;

  // item and work registers
  logic [2:0]       kind_q;
  logic [31:0]      key_q;
  logic [30:0]      tmo_q;
  logic [31:0]      now_q;
  logic [7:0]       pc_q;
  logic             last_in_q;
  status_e          status_q;
  logic [7:0]       topic_q [TOPICS];
  logic [CW-1:0]    pos_q;
  logic [TLW-1:0]   t_q;
  logic [7:0]       p_q;
  logic [TW-1:0]    tot_q;
  logic [TW-1:0]    start_q;
  logic [TW-1:0]    flen_q;
  logic [PCW-1:0]   len_q;
  logic [PCW-1:0]   k_q;
  logic [PCW-1:0]   qk_q;
  logic [PCW-1:0]   qcnt_q;
  logic [62:0]      prod_q;

  // output word registers
  logic [1:0]       st_o_q;
  logic [10:0]      pid_o_q;
  logic             has_o_q;
  logic [4:0]       acnt_o_q;
  logic             last_o_q;
  logic [3:0]       tot_o_q;
  logic [31:0]      gen_o_q;
  logic             reb_o_q;

  // memory ports
  logic             rec_re, rec_we;
  rec_t             rec_wdata, rec_rdata;
  logic [RW-1:0]    rec_rbits;
  logic             part_re, part_we;
  logic [PAW-1:0]   part_addr;
  logic [PID_W-1:0] part_wdata, part_rdata;

  // divider
  logic             div_start, div_busy;
  logic [TW-1:0]    div_quot;
  logic [CW-1:0]    div_rem;

  // shared helpers
  logic             in_fire, slot_free, at_end, key_hit, hb_late, rr_ok, rg_more;
  logic [IW-1:0]    phys;
  logic [PCW-1:0]   cnt_phys;
  logic [PCW-1:0]   kk;
  logic [PAW:0]     paddr_full;
  logic [32:0]      elapsed;
  logic [21:0]      tmo_s;
  logic [7:0]       topic_cur;
  logic [CW-1:0]    pos_inc;
  logic [TW-1:0]    flen_calc;
  logic             out_load;
  logic             out_has, out_last;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign at_end    = pos_q == n_q;
  assign phys      = map_q[pos_q[IW-1:0]];
  assign cnt_phys  = cnt_q[phys];
  assign rec_rdata = rec_t'(rec_rbits);
  assign key_hit   = rec_rdata.key == key_q;
  assign topic_cur = topic_q[t_q[TIW-1:0]];
  assign pos_inc   = CW'(pos_q + 1'b1);
  assign rr_ok     = cnt_phys < PCW'(SLOTS_PER_MEMBER);
  assign rg_more   = k_q != len_q;

  // session check: signed elapsed against timeout in whole seconds
  assign elapsed = {1'b0, now_q} - {1'b0, rec_rdata.seen};
  assign tmo_s   = prod_q[62:DIV1000_SHIFT];
  assign hb_late = $signed(elapsed) > $signed({11'b0, tmo_s});

  // range block length of the current member
  assign flen_calc = div_quot + TW'(pos_q < div_rem);

  // partition memory address: row of the member, then slot
  always_comb begin
    case (state_q)
      S_Q_RD:    kk = qk_q;
      S_RG_GIVE: kk = k_q;
      default:   kk = cnt_phys;
    endcase
  end
  assign paddr_full = (PAW+1)'(phys) * (PAW+1)'(SLOTS_PER_MEMBER) + (PAW+1)'(kk);
  assign part_addr  = paddr_full[PAW-1:0];

  // next state and memory strobes
  always_comb begin
    state_d    = state_q;
    rec_re     = 1'b0;
    rec_we     = 1'b0;
    rec_wdata  = '{key: key_q, seen: now_q, tmo: tmo_q};
    part_re    = 1'b0;
    part_we    = 1'b0;
    part_wdata = PID_W'(p_q);
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_has    = 1'b0;
    out_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (kind_q)
          K_JOIN, K_LEAVE, K_HEARTBEAT, K_QUERY: state_d = S_SRCH_RD;
          K_TOPIC: begin
            if (!last_in_q) state_d = S_EMIT;
            else if (n_q == '0) state_d = S_SYNC_END;
            else if (strat_q) state_d = S_RR;
            else state_d = S_SUM;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_SRCH_RD: begin
        if (at_end) begin
          state_d = S_EMIT;
          if (kind_q == K_JOIN && n_q < CW'(MEMBERS)) rec_we = 1'b1;
        end else begin
          rec_re  = 1'b1;
          state_d = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (!key_hit) begin
          state_d = S_SRCH_RD;
        end else begin
          case (kind_q)
            K_JOIN: begin
              rec_we    = 1'b1;
              rec_wdata = '{key: rec_rdata.key, seen: now_q, tmo: rec_rdata.tmo};
              state_d   = S_EMIT;
            end
            K_HEARTBEAT: state_d = S_HB_MUL;
            K_QUERY:     state_d = (cnt_phys == '0) ? S_EMIT : S_Q_RD;
            default:     state_d = S_EMIT;
          endcase
        end
      end
      S_HB_MUL: begin
        rec_we    = 1'b1;
        rec_wdata = '{key: rec_rdata.key, seen: now_q, tmo: rec_rdata.tmo};
        state_d   = S_HB_CMP;
      end
      S_HB_CMP: state_d = S_EMIT;
      S_Q_RD: begin
        part_re = 1'b1;
        state_d = S_Q_EMIT;
      end
      S_Q_EMIT: begin
        out_has  = 1'b1;
        out_last = PCW'(qk_q + 1'b1) == qcnt_q;
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = out_last ? S_IDLE : S_Q_RD;
        end
      end
      S_SUM: begin
        if (t_q == tl_q) state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!div_busy) state_d = S_RG_LEN;
      end
      S_RG_LEN: begin
        state_d = at_end ? S_SYNC_END : S_RG_GIVE;
      end
      S_RG_GIVE: begin
        if (rg_more) begin
          part_we    = 1'b1;
          part_wdata = PID_W'(start_q + TW'(k_q));
        end else begin
          state_d = S_RG_LEN;
        end
      end
      S_RR: begin
        if (t_q == tl_q) begin
          state_d = S_SYNC_END;
        end else if (p_q != topic_cur && rr_ok) begin
          part_we = 1'b1;
        end
      end
      S_SYNC_END: state_d = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // group state, per-member flags, counts and slot map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q     <= 1'b0;
      n_q         <= '0;
      gen_q       <= '0;
      reb_q       <= 1'b0;
      tl_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MEMBERS; i++) begin
        active_q[i] <= 1'b0;
        cnt_q[i]    <= '0;
        map_q[i]    <= IW'(i);
      end
    end else begin
      if (cfg_we_i) strat_q <= cfg_wdata_i;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_DISPATCH: begin
          if (kind_q == K_TOPIC) begin
            if (tl_q < TLW'(TOPICS)) tl_q <= TLW'(tl_q + 1'b1);
            if (last_in_q) begin
              for (int i = 0; i < MEMBERS; i++) cnt_q[i] <= '0;
            end
          end
        end
        S_SRCH_RD: begin
          // new member takes the free row at the end of the map
          if (at_end && kind_q == K_JOIN && n_q < CW'(MEMBERS)) begin
            cnt_q[phys]    <= '0;
            active_q[phys] <= 1'b1;
            n_q            <= CW'(n_q + 1'b1);
            reb_q          <= 1'b1;
            gen_q          <= gen_q + 32'd1;
          end
        end
        S_SRCH_CHK: begin
          if (key_hit && kind_q == K_JOIN) active_q[phys] <= 1'b1;
          // leave: close the gap, freed row goes to the end
          if (key_hit && kind_q == K_LEAVE) begin
            for (int i = 0; i < MEMBERS; i++) begin
              if (CW'(i) >= pos_q && CW'(i + 1) < n_q) map_q[i] <= map_q[(i + 1) % MEMBERS];
              else if (CW'(i + 1) == n_q) map_q[i] <= phys;
            end
            n_q   <= CW'(n_q - 1'b1);
            reb_q <= 1'b1;
          end
        end
        S_HB_CMP: begin
          if (hb_late) begin
            active_q[phys] <= 1'b0;
            reb_q          <= 1'b1;
          end
        end
        S_RG_GIVE: begin
          if (rg_more) cnt_q[phys] <= PCW'(cnt_phys + 1'b1);
        end
        S_RR: begin
          if (part_we) cnt_q[phys] <= PCW'(cnt_phys + 1'b1);
        end
        S_SYNC_END: begin
          reb_q <= 1'b0;
          tl_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // item capture and sequencer work registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          kind_q    <= kind_i;
          key_q     <= member_key_i;
          tmo_q     <= timeout_ms_i;
          now_q     <= now_seconds_i;
          pc_q      <= partition_count_i;
          last_in_q <= is_last_i;
        end
      end
      S_DISPATCH: begin
        status_q <= ST_OK;
        pos_q    <= '0;
        t_q      <= '0;
        p_q      <= '0;
        tot_q    <= '0;
        if (kind_q == K_TOPIC && tl_q < TLW'(TOPICS)) topic_q[tl_q[TIW-1:0]] <= pc_q;
      end
      S_SRCH_RD: begin
        if (at_end) begin
          if (kind_q == K_JOIN) status_q <= (n_q < CW'(MEMBERS)) ? ST_OK : ST_FULL;
          else status_q <= ST_NOT_FOUND;
        end
      end
      S_SRCH_CHK: begin
        if (!key_hit) pos_q <= pos_inc;
        qcnt_q <= cnt_phys;
        qk_q   <= '0;
      end
      S_HB_MUL: prod_q <= rec_rdata.tmo * DIV1000_RECIP;
      S_HB_CMP: begin
        if (hb_late) status_q <= ST_TIMEOUT;
      end
      S_Q_EMIT: begin
        if (slot_free) qk_q <= PCW'(qk_q + 1'b1);
      end
      S_SUM: begin
        if (t_q != tl_q) begin
          tot_q <= TW'(tot_q + TW'(topic_cur));
          t_q   <= TLW'(t_q + 1'b1);
        end
      end
      S_DIV_WAIT: begin
        pos_q   <= '0;
        start_q <= '0;
      end
      S_RG_LEN: begin
        flen_q <= flen_calc;
        len_q  <= (flen_calc > TW'(SLOTS_PER_MEMBER)) ? PCW'(SLOTS_PER_MEMBER)
                                                       : PCW'(flen_calc);
        k_q    <= '0;
      end
      S_RG_GIVE: begin
        if (rg_more) begin
          k_q <= PCW'(k_q + 1'b1);
        end else begin
          start_q <= TW'(start_q + flen_q);
          pos_q   <= pos_inc;
        end
      end
      S_RR: begin
        if (t_q != tl_q) begin
          if (p_q == topic_cur) begin
            t_q <= TLW'(t_q + 1'b1);
            p_q <= '0;
          end else begin
            p_q   <= p_q + 8'd1;
            pos_q <= (pos_inc == n_q) ? '0 : pos_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      st_o_q   <= out_has ? ST_OK : status_q;
      pid_o_q  <= out_has ? part_rdata : '0;
      has_o_q  <= out_has;
      acnt_o_q <= out_has ? 5'(qcnt_q) : 5'd0;
      last_o_q <= out_last;
      tot_o_q  <= 4'(n_q);
      gen_o_q  <= gen_q;
      reb_o_q  <= reb_q;
    end
  end

  cgpa_ram #(
    .W     (RW),
    .DEPTH (MEMBERS)
  ) u_rec_mem (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (phys),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (phys),
    .rdata_o (rec_rbits)
  );

  cgpa_ram #(
    .W     (PID_W),
    .DEPTH (PDEPTH)
  ) u_part_mem (
    .clk_i   (clk_i),
    .we_i    (part_we),
    .waddr_i (part_addr),
    .wdata_i (part_wdata),
    .re_i    (part_re),
    .raddr_i (part_addr),
    .rdata_o (part_rdata)
  );

  cgpa_div #(
    .NW (TW),
    .DW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tot_q),
    .den_i   (n_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign status_o         = st_o_q;
  assign partition_id_o   = pid_o_q;
  assign has_partition_o  = has_o_q;
  assign assigned_count_o = acnt_o_q;
  assign last_o           = last_o_q;
  assign member_total_o   = tot_o_q;
  assign generation_o     = gen_o_q;
  assign rebalancing_o    = reb_o_q;

endmodule

@@ design/cgpa_checker.sv @@
module cgpa_checker
  import cgpa_pkg::*;
#(
  parameter int MEMBERS = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  kind_i,
  input logic [31:0] member_key_i,
  input logic [30:0] timeout_ms_i,
  input logic [31:0] now_seconds_i,
  input logic [7:0]  partition_count_i,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [10:0] partition_id_o,
  input logic        has_partition_o,
  input logic [4:0]  assigned_count_o,
  input logic        last_o,
  input logic [3:0]  member_total_o,
  input logic [31:0] generation_o,
  input logic        rebalancing_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(partition_id_o)
      && $stable(status_o) && $stable(last_o) && $stable(generation_o))
    else $error("result word changed while stalled");

  // a partition word always reports ok and a nonzero count
  a_part_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_partition_o |-> status_o == ST_OK && assigned_count_o != 5'd0)
    else $error("partition word with bad status or count");

  // words without a partition carry no count and are last
  a_no_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_partition_o |-> assigned_count_o == 5'd0 && last_o)
    else $error("empty word with count or not last");

  // group size never exceeds the table
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(member_total_o) <= 32'(MEMBERS))
    else $error("member total above table size");

endmodule

bind consumer_group_partition_assigner cgpa_checker #(.MEMBERS(MEMBERS)) u_cgpa_checker (.*);
